FILE: design/rpa_pkg.sv
package rpa_pkg;

    typedef enum logic [2:0] {
        OP_ALLOC   = 3'd0,
        OP_FREE    = 3'd1,
        OP_ADDREF  = 3'd2,
        OP_QUERY   = 3'd3,
        OP_RANGE   = 3'd4,
        OP_RELEASE = 3'd5,
        OP_RESERVE = 3'd6,
        OP_HINT    = 3'd7
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_MEM    = 3'd1,
        ST_BAD_ADDR  = 3'd2,
        ST_DBL_FREE  = 3'd3,
        ST_SATURATED = 3'd4,
        ST_NOT_ALLOC = 3'd5,
        ST_BROKEN    = 3'd6
    } t_status;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] page_address;
        logic [31:0] range_length;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] result_address;
        logic [15:0] ref_count;
        logic        is_allocated;
        logic        in_range;
        logic [16:0] free_count;
    } t_out_item;

    // classified command passed from front to back
    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] page_address;
        logic        aligned;      // low page bits zero
        logic        addr_managed; // address below managed limit
        logic        pidx_managed; // page index below managed pages
        logic        addr_zero;
        logic        in_range;
    } t_cmd;

endpackage

FILE: design/rpa_front.sv
module rpa_front #(
    parameter int MAX_PAGES  = 65536,
    parameter int PAGE_SHIFT = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rpa_pkg::t_in_item i_item,
    input  logic [16:0]       i_page_count,
    output logic              o_valid,
    input  logic              i_ready,
    output rpa_pkg::t_cmd     o_cmd,
    output logic [$clog2(MAX_PAGES):0] o_pages
);
    localparam int PW = $clog2(MAX_PAGES) + 1;
    localparam int DEPTH = 2;

    logic [PW-1:0] pages;
    logic [47:0]   limit, a48, l48, end48;
    rpa_pkg::t_cmd cmd;

    // effective page count, saturated at MAX_PAGES
    always_comb begin
        if ({15'd0, i_page_count} > 32'(MAX_PAGES)) begin
            pages = PW'(MAX_PAGES);
        end else begin
            pages = PW'(i_page_count);
        end
        limit = 48'(pages) << PAGE_SHIFT;
        a48   = {16'd0, i_item.page_address};
        l48   = {16'd0, i_item.range_length};
        end48 = a48 + l48;
        cmd.opcode       = i_item.opcode;
        cmd.page_address = i_item.page_address;
        cmd.aligned      = (i_item.page_address[PAGE_SHIFT-1:0] == '0);
        cmd.addr_managed = (a48 < limit);
        cmd.pidx_managed = ((a48 >> PAGE_SHIFT) < 48'(pages));
        cmd.addr_zero    = (i_item.page_address == '0);
        if (i_item.range_length == '0) begin
            cmd.in_range = (a48 <= limit);
        end else begin
            cmd.in_range = (a48 < limit) && (end48 <= limit);
        end
    end
    assign o_pages = pages;

    // small queue between front and back
    rpa_pkg::t_cmd r_q [DEPTH];
    logic [1:0] r_cnt;
    logic       r_wp, r_rp;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'(DEPTH));
    assign push    = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && i_ready;
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'(DEPTH))
        else $error("queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !pop) else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'(DEPTH)) |-> !push) else $error("push into full queue");
endmodule

FILE: design/rpa_back.sv
module rpa_back #(
    parameter int MAX_PAGES  = 65536,
    parameter int PAGE_SHIFT = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  rpa_pkg::t_cmd      i_cmd,
    input  logic [$clog2(MAX_PAGES):0] i_pages,
    output logic               o_valid,
    input  logic               i_ready,
    output rpa_pkg::t_out_item o_item
);
    localparam int IW = $clog2(MAX_PAGES);
    localparam int PW = IW + 1;
    localparam int WB = 32;                   // bitmap word width
    localparam int NW = MAX_PAGES / WB;
    localparam int WW = $clog2(NW);
    localparam int BW = $clog2(WB);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_CLEAR  = 10'b0000000010,
        S_READ   = 10'b0000000100,
        S_DATA   = 10'b0000001000,
        S_SCAN   = 10'b0000010000,
        S_SDATA  = 10'b0000100000,
        S_FOUND  = 10'b0001000000,
        S_RDATA  = 10'b0010000000,
        S_REPORT = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    // used bitmap (words) and share counts; the reset sweep sets the
    // bitmap and clears every share count
    logic [WB-1:0] r_map [NW];
    logic [15:0]   r_cnt_mem [MAX_PAGES];
    logic [WB-1:0] r_word;
    logic [15:0]   r_share;

    logic          map_we, cnt_we;
    logic [WW-1:0] map_wa, map_ra;
    logic [WB-1:0] map_wd;
    logic [IW-1:0] cnt_wa, cnt_ra;
    logic [15:0]   cnt_wd;

    always_ff @(posedge i_clk) begin
        if (map_we) r_map[map_wa] <= map_wd;
        if (cnt_we) r_cnt_mem[cnt_wa] <= cnt_wd;
        r_word  <= r_map[map_ra];
        r_share <= r_cnt_mem[cnt_ra];
    end

    rpa_pkg::t_cmd      r_cmd;
    rpa_pkg::t_out_item r_out, n_out;
    logic [16:0]   r_free, n_free;
    logic [IW-1:0] r_hint, n_hint;
    logic [IW-1:0] r_page, n_page;     // page concerned
    logic [IW-1:0] r_clr, n_clr;       // clear sweep index
    logic [PW-1:0] r_scan, n_scan;     // pages scanned so far
    logic [IW-1:0] r_pos, n_pos;       // current scan page
    logic          r_rep, n_rep;       // report share count
    logic [WB-1:0] r_wsave, n_wsave;

    logic [IW-1:0] pidx;
    logic [BW-1:0] bit_i;
    logic [WB-1:0] avail;
    logic          hit;
    logic [BW-1:0] hit_b;
    logic [PW-1:0] left;
    logic [PW-1:0] wbase;

    assign pidx  = r_cmd.page_address[PAGE_SHIFT +: IW];
    assign bit_i = r_page[BW-1:0];
    assign wbase = {1'b0, r_pos[IW-1:BW], {BW{1'b0}}};

    // clear bits at or above the scan position within the word, below the
    // managed limit, also within the pages still to scan
    always_comb begin
        left  = i_pages - r_scan;
        avail = '0;
        for (int k = 0; k < WB; k++) begin
            if (k >= int'(r_pos[BW-1:0]) &&
                (k - int'(r_pos[BW-1:0])) < int'({1'b0, left}) &&
                (int'(wbase) + k) < int'(i_pages)) begin
                avail[k] = ~r_word[k];
            end
        end
        hit   = (avail != '0);
        hit_b = '0;
        for (int k = WB - 1; k >= 0; k--) begin
            if (avail[k]) hit_b = BW'(k);
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_item  = r_out;

    always_comb begin
        n_state = r_state;
        n_out   = r_out;
        n_free  = r_free;
        n_hint  = r_hint;
        n_page  = r_page;
        n_clr   = r_clr;
        n_scan  = r_scan;
        n_pos   = r_pos;
        n_rep   = r_rep;
        n_wsave = r_wsave;
        map_we  = 1'b0;
        map_wa  = r_page[IW-1:BW];
        map_wd  = r_word;
        map_ra  = r_page[IW-1:BW];
        cnt_we  = 1'b0;
        cnt_wa  = r_page;
        cnt_wd  = r_share;
        cnt_ra  = r_page;
        unique case (r_state)
            S_CLEAR: begin
                // one count entry per cycle; bitmap words while the sweep index is below NW
                map_we = (r_clr[IW-1:WW] == '0);
                map_wa = r_clr[WW-1:0];
                map_wd = '1;
                cnt_we = 1'b1;
                cnt_wa = r_clr;
                cnt_wd = '0;
                n_clr  = r_clr + 1'b1;
                if (r_clr == IW'(MAX_PAGES - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_out = '0;
                    n_out.free_count = r_free;
                    n_rep = 1'b0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                // r_cmd holds the command now
                n_page = pidx;
                map_ra = pidx[IW-1:BW];
                cnt_ra = pidx;
                n_state = S_DATA;
                unique case (rpa_pkg::t_opcode'(r_cmd.opcode))
                    rpa_pkg::OP_ALLOC: begin
                        if (r_free == '0) begin
                            n_out.status = rpa_pkg::ST_NO_MEM;
                            n_state = S_OUT;
                        end else begin
                            n_pos  = ({1'b0, r_hint} < i_pages) ? r_hint : '0;
                            n_scan = '0;
                            n_state = S_SCAN;
                        end
                    end
                    rpa_pkg::OP_RANGE: begin
                        n_out.in_range = r_cmd.in_range;
                        n_state = S_OUT;
                    end
                    rpa_pkg::OP_HINT: begin
                        if (!r_cmd.pidx_managed) begin
                            n_out.status = rpa_pkg::ST_BAD_ADDR;
                        end else begin
                            n_hint = pidx;
                        end
                        n_state = S_OUT;
                    end
                    default: ;
                endcase
            end
            S_DATA: begin
                // r_word/r_share valid for r_page
                n_state = S_REPORT;
                n_rep = r_cmd.aligned && r_cmd.addr_managed;
                n_wsave = r_word;
                case (rpa_pkg::t_opcode'(r_cmd.opcode))
                    rpa_pkg::OP_FREE: begin
                        if (r_cmd.addr_zero) begin
                            // address zero: no-op, page zero still reported
                        end else if (!(r_cmd.aligned && r_cmd.addr_managed)) begin
                            n_out.status = rpa_pkg::ST_BAD_ADDR;
                        end else if (!r_word[bit_i]) begin
                            n_out.status = rpa_pkg::ST_DBL_FREE;
                        end else if (r_share > 16'd1) begin
                            cnt_we = 1'b1;
                            cnt_wd = r_share - 16'd1;
                        end else begin
                            cnt_we = 1'b1;
                            cnt_wd = '0;
                            map_we = 1'b1;
                            map_wd = r_word & ~(WB'(1) << bit_i);
                            n_wsave = map_wd;
                            n_free = r_free + 17'd1;
                            if (r_page < r_hint) n_hint = r_page;
                        end
                    end
                    rpa_pkg::OP_ADDREF: begin
                        if (!(n_rep && r_word[bit_i])) begin
                            n_out.status = rpa_pkg::ST_NOT_ALLOC;
                        end else if (r_share == rpa_pkg::COUNT_MAX) begin
                            n_out.status = rpa_pkg::ST_SATURATED;
                        end else begin
                            cnt_we = 1'b1;
                            cnt_wd = r_share + 16'd1;
                        end
                    end
                    rpa_pkg::OP_RELEASE: begin
                        if (!r_cmd.pidx_managed) begin
                            n_out.status = rpa_pkg::ST_BAD_ADDR;
                        end else if (r_word[bit_i]) begin
                            cnt_we = 1'b1;
                            cnt_wd = '0;
                            map_we = 1'b1;
                            map_wd = r_word & ~(WB'(1) << bit_i);
                            n_wsave = map_wd;
                            n_free = r_free + 17'd1;
                        end
                    end
                    rpa_pkg::OP_RESERVE: begin
                        if (!r_cmd.pidx_managed) begin
                            n_out.status = rpa_pkg::ST_BAD_ADDR;
                        end else if (!r_word[bit_i]) begin
                            map_we = 1'b1;
                            map_wd = r_word | (WB'(1) << bit_i);
                            n_wsave = map_wd;
                            n_free = r_free - 17'd1;
                        end
                    end
                    default: ;
                endcase
            end
            S_SCAN: begin
                map_ra = r_pos[IW-1:BW];
                n_state = S_SDATA;
            end
            S_SDATA: begin
                if (hit) begin
                    n_page = {r_pos[IW-1:BW], hit_b};
                    map_we = 1'b1;
                    map_wa = r_pos[IW-1:BW];
                    map_wd = r_word | (WB'(1) << hit_b);
                    cnt_we = 1'b1;
                    cnt_wa = {r_pos[IW-1:BW], hit_b};
                    cnt_wd = 16'd1;
                    n_free = r_free - 17'd1;
                    n_state = S_FOUND;
                end else begin
                    // advance to next word, wrapping at the managed limit;
                    // only pages below the limit count as scanned
                    if (wbase + PW'(WB) >= i_pages) begin
                        n_scan = r_scan + i_pages - wbase - PW'(r_pos[BW-1:0]);
                        n_pos = '0;
                    end else begin
                        n_scan = r_scan + PW'(WB) - PW'(r_pos[BW-1:0]);
                        n_pos = {r_pos[IW-1:BW] + 1'b1, {BW{1'b0}}};
                    end
                    if (n_scan >= i_pages) begin
                        n_out.status = rpa_pkg::ST_BROKEN;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_FOUND: begin
                if ({1'b0, r_page} + 1'b1 >= i_pages) n_hint = '0;
                else n_hint = r_page + 1'b1;
                n_out.result_address = 32'({1'b0, r_page}) << PAGE_SHIFT;
                n_out.is_allocated = 1'b1;
                n_out.ref_count = 16'd1;
                n_out.free_count = r_free;
                n_state = S_OUT;
            end
            S_REPORT: begin
                // re-read share count after update
                cnt_ra = r_page;
                n_state = S_RDATA;
            end
            S_RDATA: begin
                n_out.free_count = r_free;
                if (r_rep && r_wsave[bit_i]) begin
                    n_out.is_allocated = 1'b1;
                    n_out.ref_count = r_share;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_page  <= n_page;
        r_scan  <= n_scan;
        r_pos   <= n_pos;
        r_rep   <= n_rep;
        r_wsave <= n_wsave;
        if (r_state == S_IDLE && i_valid) r_cmd <= i_cmd;
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_free  <= '0;
            r_hint  <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_free  <= n_free;
            r_hint  <= n_hint;
            r_clr   <= n_clr;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= 17'(MAX_PAGES)) else $error("free count beyond pages");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FOUND) |-> $past(hit)) else $error("found without hit");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_valid) else $error("output during clear");
endmodule

FILE: design/refcounted_page_allocator.sv
// Refcounted page allocator.
// Input channel (i_valid/o_ready) carries one command per transfer:
// alloc, free, add-ref, query, range check, release, reserve, set hint.
// Output channel (o_valid/i_ready) returns exactly one result per command.
// The front stage classifies the address (alignment, managed range, range
// check) and queues up to two commands; the back stage runs each against
// the used bitmap (32-page words) and the share-count memory.
// Range check and set hint answer straight from the classified command;
// other non-alloc ops read the bitmap word and share count, update them
// and re-read the share count. Alloc reads bitmap words one at a time from
// the hint, wrapping at the managed limit, until a clear page is found.
// One command is worked at a time in the back stage; the bitmap's single
// read port sets the scan rate.
// Reset: all pages marked used, free count and hint zero. A sweep follows
// reset, setting the bitmap and clearing the share counts; commands queue
// but do not execute until it ends. The page_count register
// (i_cfg_we/i_cfg_data) resets to 65536 and may be written only when idle.
// A stalled receiver holds the result in the output register; the front
// keeps accepting until its queue is full.
module refcounted_page_allocator #(
    parameter int MAX_PAGES  = 65536,
    parameter int PAGE_SHIFT = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  rpa_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output rpa_pkg::t_out_item o_item,
    input  logic               i_cfg_we,
    input  logic [16:0]        i_cfg_data
);
    logic [16:0] r_page_count;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_count <= 17'h10000;
        end else if (i_cfg_we) begin
            r_page_count <= i_cfg_data;
        end
    end

    rpa_pkg::t_cmd cmd;
    logic cmd_valid, cmd_ready;
    logic [$clog2(MAX_PAGES):0] pages;

    rpa_front #(.MAX_PAGES(MAX_PAGES), .PAGE_SHIFT(PAGE_SHIFT)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_item(i_item),
        .i_page_count(r_page_count),
        .o_valid(cmd_valid), .i_ready(cmd_ready), .o_cmd(cmd), .o_pages(pages)
    );

    rpa_back #(.MAX_PAGES(MAX_PAGES), .PAGE_SHIFT(PAGE_SHIFT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(cmd_valid), .o_ready(cmd_ready), .i_cmd(cmd), .i_pages(pages),
        .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item)
    );
endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    // Page allocator predictor plus store of expected results.
    class alloc_scoreboard;
        bit                 used_map [65536];
        bit [15:0]          share_cnt [65536];
        int unsigned        free_total;
        int unsigned        hint;
        int unsigned        page_reg;
        rpa_pkg::t_out_item expected_q [$];
        bit [31:0]          granted_q [$];
        int                 errors;

        function new();
            foreach (used_map[i]) used_map[i] = 1'b1;
            foreach (share_cnt[i]) share_cnt[i] = '0;
            free_total = 0;
            hint       = 0;
            page_reg   = 65536;
            errors     = 0;
        endfunction

        function void set_pages(bit [16:0] v);
            page_reg = 32'(v);
        endfunction

        function int unsigned pages();
            return (page_reg > 65536) ? 65536 : page_reg;
        endfunction

        function bit page_used(bit [63:0] a);
            bit [63:0] lim;
            lim = 64'(pages()) << 12;
            if (a[11:0] != 0 || a >= lim)
                return 1'b0;
            return used_map[a >> 12];
        endfunction

        // Work out the result of one accepted command and update state.
        function void note(rpa_pkg::t_in_item it);
            rpa_pkg::t_out_item r;
            bit [63:0]          lim, addr, len, pidx, subj;
            int unsigned        npg, start, p;
            bit                 rep;
            npg  = pages();
            lim  = 64'(npg) << 12;
            addr = 64'(it.page_address);
            len  = 64'(it.range_length);
            pidx = addr >> 12;
            subj = addr;
            rep  = 1'b1;
            r    = '0;
            r.status = rpa_pkg::ST_OK;
            case (rpa_pkg::t_opcode'(it.opcode))
                rpa_pkg::OP_ALLOC: begin
                    rep = 1'b0;
                    if (free_total == 0) begin
                        r.status = rpa_pkg::ST_NO_MEM;
                    end else begin
                        start = (hint < npg) ? hint : 0;
                        // nonzero free count but no clear page below the limit
                        r.status = rpa_pkg::ST_BROKEN;
                        for (int unsigned i = 0; i < npg; i++) begin
                            p = start + i;
                            if (p >= npg) p -= npg;
                            if (!used_map[p]) begin
                                used_map[p]  = 1'b1;
                                share_cnt[p] = 16'd1;
                                free_total--;
                                hint = (p + 1 >= npg) ? 0 : p + 1;
                                r.result_address = p << 12;
                                subj = 64'(p) << 12;
                                granted_q.push_back(r.result_address);
                                rep = 1'b1;
                                r.status = rpa_pkg::ST_OK;
                                break;
                            end
                        end
                    end
                end
                rpa_pkg::OP_FREE: begin
                    if (addr == 0) begin
                        // freeing address zero is a no-op
                    end else if (addr[11:0] != 0 || addr >= lim) begin
                        r.status = rpa_pkg::ST_BAD_ADDR;
                    end else if (!used_map[pidx]) begin
                        r.status = rpa_pkg::ST_DBL_FREE;
                    end else if (share_cnt[pidx] > 1) begin
                        share_cnt[pidx]--;
                    end else begin
                        share_cnt[pidx] = '0;
                        used_map[pidx]  = 1'b0;
                        free_total++;
                        if (pidx < 64'(hint)) hint = 32'(pidx);
                    end
                end
                rpa_pkg::OP_ADDREF: begin
                    if (!page_used(addr))
                        r.status = rpa_pkg::ST_NOT_ALLOC;
                    else if (share_cnt[pidx] == rpa_pkg::COUNT_MAX)
                        r.status = rpa_pkg::ST_SATURATED;
                    else
                        share_cnt[pidx]++;
                end
                rpa_pkg::OP_QUERY: ;
                rpa_pkg::OP_RANGE: begin
                    rep = 1'b0;
                    if (len == 0)
                        r.in_range = (addr <= lim);
                    else
                        r.in_range = (addr < lim) && (len <= lim - addr);
                end
                rpa_pkg::OP_RELEASE: begin
                    if (pidx >= 64'(npg)) begin
                        r.status = rpa_pkg::ST_BAD_ADDR;
                    end else if (used_map[pidx]) begin
                        used_map[pidx]  = 1'b0;
                        share_cnt[pidx] = '0;
                        free_total++;
                    end
                end
                rpa_pkg::OP_RESERVE: begin
                    if (pidx >= 64'(npg)) begin
                        r.status = rpa_pkg::ST_BAD_ADDR;
                    end else if (!used_map[pidx]) begin
                        used_map[pidx] = 1'b1;
                        free_total--;
                    end
                end
                default: begin
                    rep = 1'b0;
                    if (pidx >= 64'(npg)) r.status = rpa_pkg::ST_BAD_ADDR;
                    else hint = 32'(pidx);
                end
            endcase
            if (rep && page_used(subj)) begin
                r.ref_count    = share_cnt[subj >> 12];
                r.is_allocated = 1'b1;
            end
            r.free_count = free_total[16:0];
            expected_q.push_back(r);
        endfunction

        function void check(rpa_pkg::t_out_item act);
            rpa_pkg::t_out_item e;
            if (expected_q.size() == 0) begin
                $display("%0t: result with nothing expected: st=%0d addr=%h rc=%0d",
                         $time, act.status, act.result_address, act.ref_count);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (act !== e) begin
                $display("%0t: mismatch exp st=%0d addr=%h rc=%0d alloc=%0b rng=%0b free=%0d",
                         $time, e.status, e.result_address, e.ref_count,
                         e.is_allocated, e.in_range, e.free_count);
                $display("%0t:          act st=%0d addr=%h rc=%0d alloc=%0b rng=%0b free=%0d",
                         $time, act.status, act.result_address, act.ref_count,
                         act.is_allocated, act.in_range, act.free_count);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    rpa_pkg::t_in_item  i_item = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    rpa_pkg::t_out_item o_item;
    logic               i_cfg_we = 1'b0;
    logic [16:0]        i_cfg_data = '0;

    alloc_scoreboard sb;
    bit send_idle;            // sender idles with idle_pct percent chance per try
    bit recv_stall;           // receiver stalls with stall_pct percent chance
    int unsigned idle_pct  = 72;
    int unsigned stall_pct = 72;

    refcounted_page_allocator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_item     (o_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Receiver: ready changes on the falling edge only.
    always @(negedge i_clk) begin
        i_ready <= recv_stall ? ($urandom_range(99) >= stall_pct) : 1'b1;
    end

    // Every transfer on the result channel is checked at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check(o_item);
    end

    // Entered and left at a falling edge. Valid holds until the transfer.
    task automatic send(rpa_pkg::t_opcode op, bit [31:0] addr, bit [31:0] len);
        rpa_pkg::t_in_item it;
        it.opcode       = op;
        it.page_address = addr;
        it.range_length = len;
        while (send_idle && $urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (!o_ready);
        sb.note(it);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    // Register writes only with the block idle.
    task automatic write_pages(bit [16:0] v);
        drain();
        repeat (12) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_pages(v);
    endtask

    // Mostly aligned pages around the managed range; some zero, misaligned, wild.
    function automatic bit [31:0] pick_addr(int unsigned span);
        int unsigned k;
        k = $urandom_range(99);
        if (k < 70) return $urandom_range(span + 1) << 12;
        if (k < 78) return 32'h0;
        if (k < 88) return ($urandom_range(span + 1) << 12) | $urandom_range(4095, 1);
        return $urandom();
    endfunction

    task automatic random_ops(int n, int unsigned span);
        int unsigned k, idx;
        bit [31:0]   a, len;
        for (int i = 0; i < n; i++) begin
            // occasional hold-off until the block has drained
            if ($urandom_range(79) == 0) drain();
            k = $urandom_range(99);
            a = pick_addr(span);
            if (k < 30) begin
                send(rpa_pkg::OP_ALLOC, $urandom(), $urandom());
            end else if (k < 55) begin
                if (sb.granted_q.size() != 0 && $urandom_range(9) < 7) begin
                    idx = $urandom_range(sb.granted_q.size() - 1);
                    a = sb.granted_q[idx];
                    sb.granted_q.delete(idx);
                end
                send(rpa_pkg::OP_FREE, a, $urandom());
            end else if (k < 65) begin
                if (sb.granted_q.size() != 0 && $urandom_range(1))
                    a = sb.granted_q[$urandom_range(sb.granted_q.size() - 1)];
                send(rpa_pkg::OP_ADDREF, a, $urandom());
            end else if (k < 72) begin
                send(rpa_pkg::OP_QUERY, a, $urandom());
            end else if (k < 79) begin
                case ($urandom_range(2))
                    0: len = 32'h0;
                    1: len = $urandom_range(span + 2) << 12;
                    default: len = $urandom();
                endcase
                send(rpa_pkg::OP_RANGE, a, len);
            end else if (k < 88) begin
                send(rpa_pkg::OP_RELEASE, a | $urandom_range(4095), $urandom());
            end else if (k < 94) begin
                send(rpa_pkg::OP_RESERVE, a | $urandom_range(4095), $urandom());
            end else begin
                send(rpa_pkg::OP_HINT, a, $urandom());
            end
        end
    endtask

    initial begin
        sb = new();
        send_idle  = 1'b0;
        recv_stall = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at the default 65536 pages, every page used.
        send(rpa_pkg::OP_ALLOC,   32'h0,         32'h0);   // no memory
        send(rpa_pkg::OP_RELEASE, 32'h0,         32'h0);
        send(rpa_pkg::OP_RELEASE, 32'h0000_5123, 32'h0);   // low bits ignored
        send(rpa_pkg::OP_RELEASE, 32'hFFFF_F000, 32'h0);   // unmanaged
        send(rpa_pkg::OP_RELEASE, 32'h0FFF_F000, 32'h0);   // last page
        send(rpa_pkg::OP_RELEASE, 32'h0,         32'h0);   // already free
        send(rpa_pkg::OP_ALLOC,   32'h0,         32'h0);
        send(rpa_pkg::OP_ALLOC,   32'h0,         32'h0);
        send(rpa_pkg::OP_ALLOC,   32'h0,         32'h0);   // long scan to top page
        send(rpa_pkg::OP_FREE,    32'h0,         32'h0);   // address zero no-op
        send(rpa_pkg::OP_FREE,    32'h0000_5004, 32'h0);   // misaligned
        send(rpa_pkg::OP_FREE,    32'h1000_0000, 32'h0);   // beyond limit
        send(rpa_pkg::OP_ADDREF,  32'h0000_5000, 32'h0);
        send(rpa_pkg::OP_FREE,    32'h0000_5000, 32'h0);
        send(rpa_pkg::OP_FREE,    32'h0000_5000, 32'h0);
        send(rpa_pkg::OP_FREE,    32'h0000_5000, 32'h0);   // double free
        send(rpa_pkg::OP_ADDREF,  32'h0000_5000, 32'h0);   // not allocated
        send(rpa_pkg::OP_RESERVE, 32'h0000_5FFF, 32'h0);
        send(rpa_pkg::OP_RESERVE, 32'h0000_5000, 32'h0);   // already used
        send(rpa_pkg::OP_RESERVE, 32'hFFFF_FFFF, 32'h0);
        send(rpa_pkg::OP_RANGE,   32'h1000_0000, 32'h0);   // empty range at limit
        send(rpa_pkg::OP_RANGE,   32'h1000_0000, 32'h1);
        send(rpa_pkg::OP_RANGE,   32'h0,         32'h1000_0000);
        send(rpa_pkg::OP_RANGE,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(rpa_pkg::OP_HINT,    32'h0FFF_F000, 32'h0);
        send(rpa_pkg::OP_HINT,    32'hFFFF_FFFF, 32'h0);   // hint out of range

        // Share count walks up on page 0.
        repeat (3) send(rpa_pkg::OP_ADDREF, 32'h0, 32'h0);
        send(rpa_pkg::OP_QUERY,  32'h0, 32'h0);

        // Random phases across settings and idling modes.
        write_pages(17'd40);
        random_ops(200, 40);
        write_pages(17'd0);
        random_ops(15, 4);
        write_pages(17'd1);
        send_idle = 1'b1;
        random_ops(120, 2);
        write_pages(17'd200);
        send_idle  = 1'b0;
        recv_stall = 1'b1;
        random_ops(200, 200);
        write_pages(17'd40);       // shrink with free pages left above
        send_idle = 1'b1;
        idle_pct  = 29;
        stall_pct = 29;
        random_ops(180, 60);
        write_pages(17'h1FFFF);    // saturates to the maximum
        send_idle  = 1'b0;
        recv_stall = 1'b0;
        random_ops(80, 300);

        drain();
        repeat (40) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[refcounted_page_allocator] OK");
        else
            $display("[refcounted_page_allocator] ERROR");
        $finish;
    end

    initial begin
        #200_000_000;
        $display("[refcounted_page_allocator] ERROR");
        $finish;
    end

endmodule
